[sv/lcr_pkg.sv]
`default_nettype none

package lcr_pkg;

   localparam int DATA_W = 32;
   localparam int CMD_W = 3;
   localparam int REQ_W = 3;
   localparam int ACTIVE_W = 4;
   localparam int CSR_IDX_W = 1;
   localparam int REQUESTERS_DEFAULT = 8;

   localparam logic [DATA_W-1:0] LIMIT_RESET = 32'd10000;
   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_LIMIT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_REQUESTERS = 1'b1;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD = 3'd0,
      CMD_SUB = 3'd1,
      CMD_READ = 3'd2,
      CMD_REGISTER = 3'd3,
      CMD_UNREGISTER = 3'd4
   } cmd_type;

   typedef struct packed {
      logic start;
      logic [DATA_W-1:0] dividend;
      logic [ACTIVE_W-1:0] divisor;
   } div_ctl_type;

   typedef struct packed {
      logic done;
      logic [DATA_W-1:0] quotient;
   } div_sts_type;

   function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
      logic [DATA_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[DATA_W] ? {DATA_W{1'b1}} : s[DATA_W-1:0];
   endfunction

   function automatic logic [DATA_W-1:0] sat_sub(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
      return (a >= b) ? (a - b) : '0;
   endfunction

endpackage

`default_nettype wire

[sv/limit_counter_with_local_reserves.sv]
// Split limit counter: a shared pool plus a local count and ceiling per requester.
// Requests arrive on the req_ channel (command, requester, delta); each one gives
// exactly one result on the rsp_ channel (ok, total). A transfer takes place at a
// rising clock edge where valid is high and stall is low.
// The block works on one request at a time and holds req_stall high while busy.
// Steps after a request transfer: a register goes straight to the result; an add
// or subtract inside the local slack and an unregister first update the local
// entry; an add or subtract that goes to the pool checks the pool and then runs a
// one-bit-per-cycle divider over all 32 bits; a failed pool check ends there; a
// read sums the local counts one RAM read at a time. A new request can be taken
// in the same cycle that the result goes valid.
// A finished result sits in an output register; a new request is taken while it
// waits. If the receiver stalls and a second result is ready, the sequencer holds
// that result and keeps req_stall high until the output register frees up.
// Synchronous reset loads count_limit with 10000 and active_requesters with 8 and
// clears the pool, the reserve, all registrations and all local entries at once.
// The csr_ port writes count_limit (index 0) or active_requesters (index 1) at any
// edge where csr_write_enable is high; write only while the block is idle.
`default_nettype none

module limit_counter_with_local_reserves #(
   parameter int REQUESTERS = lcr_pkg::REQUESTERS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [lcr_pkg::CMD_W-1:0]     req_command,
   input  wire logic [lcr_pkg::REQ_W-1:0]     req_requester,
   input  wire logic [lcr_pkg::DATA_W-1:0]    req_delta,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_ok,
   output logic [lcr_pkg::DATA_W-1:0]         rsp_total,
   input  wire logic                          csr_write_enable,
   input  wire logic [lcr_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [lcr_pkg::DATA_W-1:0]    csr_write_data
);

   localparam int IDX_W = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;
   localparam int DW = lcr_pkg::DATA_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_CHECK,
      ST_DIVLOAD,
      ST_DIV,
      ST_REBAL,
      ST_SUM_WAIT,
      ST_SUM_ACC,
      ST_FINISH
   } state_type;

   state_type                        state_ff, state_in;
   lcr_pkg::cmd_type                 cmd_ff, cmd_in;
   logic [IDX_W-1:0]                 idx_ff, idx_in;
   logic [DW-1:0]                    delta_ff, delta_in;
   logic                             ok_ff, ok_in;
   logic [DW-1:0]                    sum_ff, sum_in;
   logic [DW-1:0]                    pool_ff, pool_in;
   logic [DW-1:0]                    reserve_ff, reserve_in;
   logic [DW-1:0]                    limit_ff;
   logic [lcr_pkg::ACTIVE_W-1:0]     active_ff;
   logic [REQUESTERS-1:0]            registered_ff, registered_in;
   logic [REQUESTERS-1:0]            entry_valid_ff, entry_valid_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_ok_ff, rsp_ok_in;
   logic [DW-1:0]                    rsp_total_ff, rsp_total_in;

   logic                             req_accept;
   logic [6:0]                       req_ext;
   logic                             req_idx_ok;
   logic [IDX_W-1:0]                 req_idx;
   logic [IDX_W-1:0]                 rd_addr;
   logic [DW-1:0]                    cnt_q, ceil_q;
   logic [DW-1:0]                    lc, lcl;
   logic [DW-1:0]                    headroom;
   logic [DW-1:0]                    give;
   logic                             ram_we;
   logic [DW-1:0]                    wr_count, wr_ceil;
   lcr_pkg::div_ctl_type             div_ctl;
   lcr_pkg::div_sts_type             div_sts;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign req_ext = {4'b0000, req_requester};
   assign req_idx_ok = (req_ext < 7'(REQUESTERS));
   assign req_idx = req_ext[IDX_W-1:0];
   assign rd_addr = (state_ff == ST_IDLE) ? req_idx : idx_ff;

   assign lc = entry_valid_ff[idx_ff] ? cnt_q : '0;
   assign lcl = entry_valid_ff[idx_ff] ? ceil_q : '0;
   assign headroom = lcr_pkg::sat_sub(lcr_pkg::sat_sub(limit_ff, pool_ff), reserve_ff);
   assign give = ((div_sts.quotient >> 1) > pool_ff) ? pool_ff : (div_sts.quotient >> 1);

   lcr_ram #(.WIDTH(DW), .DEPTH(REQUESTERS)) u_count_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx_ff),
      .wr_data (wr_count),
      .rd_addr (rd_addr),
      .rd_data (cnt_q)
   );

   lcr_ram #(.WIDTH(DW), .DEPTH(REQUESTERS)) u_ceiling_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx_ff),
      .wr_data (wr_ceil),
      .rd_addr (rd_addr),
      .rd_data (ceil_q)
   );

   lcr_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .sts   (div_sts)
   );

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      idx_in = idx_ff;
      delta_in = delta_ff;
      ok_in = ok_ff;
      sum_in = sum_ff;
      pool_in = pool_ff;
      reserve_in = reserve_ff;
      registered_in = registered_ff;
      entry_valid_in = entry_valid_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ok_in = rsp_ok_ff;
      rsp_total_in = rsp_total_ff;
      ram_we = 1'b0;
      wr_count = '0;
      wr_ceil = '0;
      div_ctl.start = 1'b0;
      div_ctl.dividend = headroom;
      div_ctl.divisor = (active_ff == '0) ? lcr_pkg::ACTIVE_W'(1) : active_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in = lcr_pkg::cmd_type'(req_command);
               idx_in = req_idx;
               delta_in = req_delta;
               ok_in = 1'b0;
               sum_in = '0;
               state_in = ST_FINISH;
               if (req_idx_ok) begin
                  case (req_command)
                     lcr_pkg::CMD_ADD, lcr_pkg::CMD_SUB, lcr_pkg::CMD_UNREGISTER: begin
                        state_in = ST_DECIDE;
                     end
                     lcr_pkg::CMD_READ: begin
                        sum_in = pool_ff;
                        idx_in = '0;
                        state_in = ST_SUM_WAIT;
                     end
                     lcr_pkg::CMD_REGISTER: begin
                        registered_in[req_idx] = 1'b1;
                        ok_in = 1'b1;
                     end
                     default: begin
                        ok_in = 1'b0;
                     end
                  endcase
               end
            end
         end
         ST_DECIDE: begin
            ram_we = 1'b1;
            entry_valid_in[idx_ff] = 1'b1;
            if (cmd_ff == lcr_pkg::CMD_ADD && lcr_pkg::sat_sub(lcl, lc) >= delta_ff) begin
               wr_count = lc + delta_ff;
               wr_ceil = lcl;
               ok_in = 1'b1;
               state_in = ST_FINISH;
            end else if (cmd_ff == lcr_pkg::CMD_SUB && lc >= delta_ff) begin
               wr_count = lc - delta_ff;
               wr_ceil = lcl;
               ok_in = 1'b1;
               state_in = ST_FINISH;
            end else begin
               pool_in = lcr_pkg::sat_add(pool_ff, lc);
               reserve_in = lcr_pkg::sat_sub(reserve_ff, lcl);
               if (cmd_ff == lcr_pkg::CMD_UNREGISTER) begin
                  registered_in[idx_ff] = 1'b0;
                  ok_in = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (cmd_ff == lcr_pkg::CMD_ADD) begin
               if (headroom < delta_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  pool_in = pool_ff + delta_ff;
                  state_in = ST_DIVLOAD;
               end
            end else begin
               if (pool_ff < delta_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  pool_in = pool_ff - delta_ff;
                  state_in = ST_DIVLOAD;
               end
            end
         end
         ST_DIVLOAD: begin
            div_ctl.start = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_sts.done) begin
               state_in = ST_REBAL;
            end
         end
         ST_REBAL: begin
            ram_we = 1'b1;
            entry_valid_in[idx_ff] = 1'b1;
            wr_count = give;
            wr_ceil = div_sts.quotient;
            reserve_in = lcr_pkg::sat_add(reserve_ff, div_sts.quotient);
            pool_in = pool_ff - give;
            ok_in = 1'b1;
            state_in = ST_FINISH;
         end
         ST_SUM_WAIT: begin
            state_in = ST_SUM_ACC;
         end
         ST_SUM_ACC: begin
            if (registered_ff[idx_ff]) begin
               sum_in = lcr_pkg::sat_add(sum_ff, lc);
            end
            if (idx_ff == IDX_W'(REQUESTERS - 1)) begin
               ok_in = 1'b1;
               state_in = ST_FINISH;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
               state_in = ST_SUM_WAIT;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in = ok_ff;
               rsp_total_in = sum_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pool_ff <= '0;
         reserve_ff <= '0;
         limit_ff <= lcr_pkg::LIMIT_RESET;
         active_ff <= lcr_pkg::ACTIVE_RESET;
         registered_ff <= '0;
         entry_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pool_ff <= pool_in;
         reserve_ff <= reserve_in;
         registered_ff <= registered_in;
         entry_valid_ff <= entry_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               lcr_pkg::CSR_COUNT_LIMIT: begin
                  limit_ff <= csr_write_data;
               end
               lcr_pkg::CSR_ACTIVE_REQUESTERS: begin
                  active_ff <= csr_write_data[lcr_pkg::ACTIVE_W-1:0];
               end
               default: begin
                  limit_ff <= limit_ff;
               end
            endcase
         end
      end
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      delta_ff <= delta_in;
      ok_ff <= ok_in;
      sum_ff <= sum_in;
      rsp_ok_ff <= rsp_ok_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ok = rsp_ok_ff;
   assign rsp_total = rsp_total_ff;

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> state_ff == ST_DIV)
      else $error("divider finished outside of its wait state");

   a_fail_total_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_total == '0)
      else $error("failed result carries a nonzero total");

   a_ram_write_busy: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_DECIDE || state_ff == ST_REBAL))
      else $error("local entry written outside an update step");

   a_rsp_load_on_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && rsp_valid_ff && rsp_stall |=> state_ff == ST_FINISH)
      else $error("result left the sequencer while the output register was full");

endmodule

`default_nettype wire

[sv/lcr_ram.sv]
`default_nettype none

module lcr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/lcr_div.sv]
`default_nettype none

module lcr_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lcr_pkg::div_ctl_type ctl,
   output lcr_pkg::div_sts_type      sts
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [4:0]                        cnt_ff, cnt_in;
   logic [lcr_pkg::ACTIVE_W-1:0]      rem_ff, rem_in;
   logic [lcr_pkg::ACTIVE_W-1:0]      divisor_ff, divisor_in;
   logic [lcr_pkg::DATA_W-1:0]        quo_ff, quo_in;
   logic [lcr_pkg::ACTIVE_W:0]        trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      divisor_in = divisor_ff;
      quo_in = quo_ff;
      trial = {rem_ff, quo_ff[lcr_pkg::DATA_W-1]};
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         divisor_in = ctl.divisor;
         quo_in = ctl.dividend;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in = lcr_pkg::ACTIVE_W'(trial - {1'b0, divisor_ff});
            quo_in = {quo_ff[lcr_pkg::DATA_W-2:0], 1'b1};
         end else begin
            rem_in = trial[lcr_pkg::ACTIVE_W-1:0];
            quo_in = {quo_ff[lcr_pkg::DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      divisor_ff <= divisor_in;
      quo_ff <= quo_in;
   end

   assign sts.done = done_ff;
   assign sts.quotient = quo_ff;

endmodule

`default_nettype wire
